// File: hdl/sliding_anagram_detector_unit_macros.svh
// assertion macros used by the anagram detector core
`ifndef SLIDING_ANAGRAM_DETECTOR_UNIT_MACROS_SVH
`define SLIDING_ANAGRAM_DETECTOR_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled during reset
`define SAD_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sad: same-cycle check failed");

// next-cycle implication, disabled during reset
`define SAD_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sad: next-cycle check failed");

`else

`define SAD_ASSERT_IMP(name, clk, rst_n, ante, cons)

`define SAD_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

// File: hdl/sad_pkg.sv
// shared types, constants and helper functions of the anagram detector
`timescale 1ns / 1ps

package sad_pkg;

    // sizing
    localparam int MAX_PATTERN   = 16;
    localparam int POSITION_BITS = 16;
    localparam int LEN_BITS      = $clog2(MAX_PATTERN + 1);
    localparam int BYTE_BITS     = 8;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 64;
    localparam int LEN_REG_BITS  = 5;
    localparam int START_BITS    = 16;
    localparam int START_WIDE    = (POSITION_BITS > START_BITS) ? POSITION_BITS : START_BITS;
    localparam int COUNT_GROUPS  = (MAX_PATTERN + 3) / 4;

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    // configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_PATTERN_LENGTH = 2'd0,
        CFG_PATTERN_LOW    = 2'd1,
        CFG_PATTERN_HIGH   = 2'd2
    } t_cfg_index;

    // input item
    typedef struct packed {
        logic [BYTE_BITS-1:0] text_byte;
        logic                 first_of_text;
    } t_in_item;

    // result item
    typedef struct packed {
        logic                  match;
        logic [START_BITS-1:0] window_start;
        logic                  position_overflow;
    } t_out_item;

    // pattern view handed from the register file to the core
    typedef struct packed {
        logic [LEN_BITS-1:0]                        len;
        logic [MAX_PATTERN-1:0][BYTE_BITS-1:0]      bytes;
        logic [MAX_PATTERN-1:0][LEN_BITS-1:0]       need;
    } t_pat_cfg;

    // zero means one, anything above the maximum means the maximum
    function automatic logic [LEN_BITS-1:0] clamp_length(input logic [LEN_REG_BITS-1:0] v);
        logic [LEN_BITS-1:0] r;
        if (v == '0) begin
            r = LEN_BITS'(1);
        end else if (32'(v) > MAX_PATTERN) begin
            r = LEN_BITS'(MAX_PATTERN);
        end else begin
            r = LEN_BITS'(v);
        end
        return r;
    endfunction

    // population count as nibble sums followed by a short add chain
    function automatic logic [LEN_BITS-1:0] count_ones(input logic [MAX_PATTERN-1:0] v);
        logic [4*COUNT_GROUPS-1:0] padded;
        logic [2:0]                grp_sum;
        logic [LEN_BITS-1:0]       total;
        padded = (4*COUNT_GROUPS)'(v);
        total  = '0;
        for (int g = 0; g < COUNT_GROUPS; g++) begin
            grp_sum = 3'(padded[4*g]) + 3'(padded[4*g+1])
                    + 3'(padded[4*g+2]) + 3'(padded[4*g+3]);
            total   = total + LEN_BITS'(grp_sum);
        end
        return total;
    endfunction

endpackage

// File: hdl/sliding_anagram_detector_unit.sv
// Sliding-window anagram search over a byte stream. Each accepted text byte yields
// one result: match is 1 when the last pattern_length bytes of the current text are a
// permutation of the first pattern_length pattern bytes, window_start then gives the
// text position of the oldest byte of that window, and position_overflow flags bytes
// whose position could no longer be counted because the 16-bit position counter had
// stuck at its maximum. A byte with first_of_text set latches the pattern and its length
// and restarts the window and the position at zero; register writes take effect at the
// next such byte. Before the first start of text every byte matches at its own position.
// One byte can be taken every clock cycle while the output is not stalled. A taken byte
// waits in the input register and moves into the result register, which offers its
// result, at the next edge at which that register is empty or draining. While a finished
// result waits on a stalled output the input register can still take one more byte, and
// the input stalls after that. The whole window compare runs in the single stage between
// those two registers. Configuration writes are always ready and should only be issued
// while no byte is in flight.
`timescale 1ns / 1ps

module sliding_anagram_detector_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // text bytes in
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  sad_pkg::t_in_item                  i_in_data,
    // results out
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output sad_pkg::t_out_item                 o_out_data,
    // register writes
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [sad_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [sad_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);

    logic               r_in_vld;
    sad_pkg::t_in_item  r_in_data;
    logic               r_out_vld;
    sad_pkg::t_out_item r_out_data;
    logic               n_in_vld;
    logic               n_out_vld;

    logic               out_can_load;
    logic               proc_fire;
    logic               in_fire;
    logic               out_fire;
    sad_pkg::t_pat_cfg  pat;
    sad_pkg::t_out_item result;

    // register file
    assign o_cfg_ready = 1'b1;

    sad_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (i_cfg_valid & o_cfg_ready),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_pat      (pat)
    );

    // pipeline handshake
    assign out_fire     = r_out_vld & ~i_out_stall;
    assign out_can_load = ~r_out_vld | ~i_out_stall;
    assign proc_fire    = r_in_vld & out_can_load;
    assign o_in_stall   = r_in_vld & ~out_can_load;
    assign in_fire      = i_in_valid & ~o_in_stall;

    always_comb begin
        n_in_vld  = in_fire | (r_in_vld & ~proc_fire);
        n_out_vld = proc_fire | (r_out_vld & ~out_fire);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_data <= i_in_data;
        end
    end

    // window and match logic
    sad_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (proc_fire),
        .i_item   (r_in_data),
        .i_pat    (pat),
        .o_result (result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (proc_fire) begin
            r_out_data <= result;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out_data;

endmodule

// File: hdl/sad_cfg.sv
// configuration registers and per-byte pattern multiplicities
`timescale 1ns / 1ps

module sad_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_wr,
    input  logic [sad_pkg::CFG_IDX_BITS-1:0]   i_wr_index,
    input  logic [sad_pkg::CFG_DATA_BITS-1:0]  i_wr_data,
    output sad_pkg::t_pat_cfg                  o_pat
);

    logic [sad_pkg::LEN_REG_BITS-1:0]  r_len_raw;
    logic [sad_pkg::CFG_DATA_BITS-1:0] r_pat_lo;
    logic [sad_pkg::CFG_DATA_BITS-1:0] r_pat_hi;
    logic [sad_pkg::MAX_PATTERN-1:0][sad_pkg::LEN_BITS-1:0] r_need;
    logic [sad_pkg::MAX_PATTERN-1:0][sad_pkg::LEN_BITS-1:0] n_need;

    logic [2*sad_pkg::CFG_DATA_BITS-1:0] pat_all;
    logic [sad_pkg::LEN_BITS-1:0]        len_c;
    logic [sad_pkg::MAX_PATTERN-1:0][sad_pkg::BYTE_BITS-1:0] bytes;
    logic [sad_pkg::MAX_PATTERN-1:0][sad_pkg::MAX_PATTERN-1:0] same_map;

    // register writes, unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_raw <= sad_pkg::LEN_REG_BITS'(1);
            r_pat_lo  <= '0;
            r_pat_hi  <= '0;
        end else if (i_wr) begin
            case (i_wr_index)
                sad_pkg::CFG_PATTERN_LENGTH: r_len_raw <= i_wr_data[sad_pkg::LEN_REG_BITS-1:0];
                sad_pkg::CFG_PATTERN_LOW:    r_pat_lo  <= i_wr_data;
                sad_pkg::CFG_PATTERN_HIGH:   r_pat_hi  <= i_wr_data;
                default: ;
            endcase
        end
    end

    // byte view of the pattern and clamped length
    assign pat_all = {r_pat_hi, r_pat_lo};
    assign len_c   = sad_pkg::clamp_length(r_len_raw);

    always_comb begin
        for (int k = 0; k < sad_pkg::MAX_PATTERN; k++) begin
            bytes[k] = pat_all[sad_pkg::BYTE_BITS*k +: sad_pkg::BYTE_BITS];
        end
    end

    // how often each pattern byte occurs among the bytes in use
    always_comb begin
        for (int k = 0; k < sad_pkg::MAX_PATTERN; k++) begin
            for (int j = 0; j < sad_pkg::MAX_PATTERN; j++) begin
                same_map[k][j] = (j < int'(len_c)) && (bytes[j] == bytes[k]);
            end
            n_need[k] = sad_pkg::count_ones(same_map[k]);
        end
    end

    // multiplicities are registered, so they follow the registers in the next cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_need <= '0;
        end else begin
            r_need <= n_need;
        end
    end

    assign o_pat.len   = len_c;
    assign o_pat.bytes = bytes;
    assign o_pat.need  = r_need;

endmodule

// File: hdl/sad_core.sv
// window, position and match logic for one text byte per transfer
`timescale 1ns / 1ps
`include "sliding_anagram_detector_unit_macros.svh"

module sad_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  sad_pkg::t_in_item  i_item,
    input  sad_pkg::t_pat_cfg  i_pat,
    output sad_pkg::t_out_item o_result
);

    // state of the current text
    logic [sad_pkg::MAX_PATTERN-1:0][sad_pkg::BYTE_BITS-1:0] r_win;
    logic [sad_pkg::MAX_PATTERN-1:0][sad_pkg::BYTE_BITS-1:0] r_act_bytes;
    logic [sad_pkg::MAX_PATTERN-1:0][sad_pkg::LEN_BITS-1:0]  r_act_need;
    logic [sad_pkg::LEN_BITS-1:0]      r_act_len;
    logic                              r_loaded;
    logic [sad_pkg::LEN_BITS-1:0]      r_fill;
    logic [sad_pkg::POSITION_BITS-1:0] r_pos;
    logic                              r_sat;

    // values in effect for this byte
    logic [sad_pkg::MAX_PATTERN-1:0][sad_pkg::BYTE_BITS-1:0] cur_bytes;
    logic [sad_pkg::MAX_PATTERN-1:0][sad_pkg::LEN_BITS-1:0]  cur_need;
    logic [sad_pkg::LEN_BITS-1:0]      cur_len;
    logic                              cur_loaded;
    logic [sad_pkg::LEN_BITS-1:0]      cur_fill;
    logic [sad_pkg::POSITION_BITS-1:0] cur_pos;
    logic                              cur_sat;

    logic [sad_pkg::MAX_PATTERN-1:0][sad_pkg::BYTE_BITS-1:0] n_win;
    logic [sad_pkg::LEN_BITS-1:0]      n_fill;
    logic [sad_pkg::POSITION_BITS-1:0] n_pos;
    logic                              n_sat;

    logic [sad_pkg::MAX_PATTERN-1:0][sad_pkg::MAX_PATTERN-1:0] hit_map;
    logic [sad_pkg::MAX_PATTERN-1:0]   slot_ok;
    logic                              hit;
    logic [sad_pkg::POSITION_BITS-1:0] start_pos;
    logic [sad_pkg::START_WIDE-1:0]    start_wide;

    // a first-of-text byte takes the pattern from the register file
    always_comb begin
        cur_bytes  = i_item.first_of_text ? i_pat.bytes : r_act_bytes;
        cur_need   = i_item.first_of_text ? i_pat.need  : r_act_need;
        cur_len    = i_item.first_of_text ? i_pat.len   : r_act_len;
        cur_loaded = i_item.first_of_text | r_loaded;
        cur_fill   = i_item.first_of_text ? '0 : r_fill;
        cur_pos    = i_item.first_of_text ? '0 : r_pos;
        cur_sat    = i_item.first_of_text ? 1'b0 : r_sat;
    end

    // window shifts with the newest byte in slot zero
    always_comb begin
        n_win[0] = i_item.text_byte;
        for (int j = 1; j < sad_pkg::MAX_PATTERN; j++) begin
            n_win[j] = r_win[j-1];
        end
        n_fill = (cur_fill >= cur_len) ? cur_len : cur_fill + sad_pkg::LEN_BITS'(1);
    end

    // each pattern byte must appear in the window at least as often as in the pattern
    always_comb begin
        for (int k = 0; k < sad_pkg::MAX_PATTERN; k++) begin
            for (int j = 0; j < sad_pkg::MAX_PATTERN; j++) begin
                hit_map[k][j] = (j < int'(cur_len)) && (n_win[j] == cur_bytes[k]);
            end
            slot_ok[k] = !(cur_loaded && (k < int'(cur_len)))
                       || (cur_need[k] <= sad_pkg::count_ones(hit_map[k]));
        end
        hit = (n_fill == cur_len) && (&slot_ok);
    end

    // position counter sticks at its maximum
    always_comb begin
        n_pos = (cur_pos == sad_pkg::POS_MAX) ? cur_pos
                                              : cur_pos + sad_pkg::POSITION_BITS'(1);
        n_sat = cur_sat | (cur_pos == sad_pkg::POS_MAX);
    end

    // start of the matching window
    always_comb begin
        start_pos  = cur_pos - (sad_pkg::POSITION_BITS'(cur_len) - sad_pkg::POSITION_BITS'(1));
        start_wide = sad_pkg::START_WIDE'(start_pos);
    end

    assign o_result.match             = hit;
    assign o_result.window_start      = hit ? start_wide[sad_pkg::START_BITS-1:0] : '0;
    assign o_result.position_overflow = cur_sat;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act_len <= sad_pkg::LEN_BITS'(1);
            r_loaded  <= 1'b0;
            r_fill    <= '0;
            r_pos     <= '0;
            r_sat     <= 1'b0;
        end else if (i_fire) begin
            r_act_len <= cur_len;
            r_loaded  <= cur_loaded;
            r_fill    <= n_fill;
            r_pos     <= n_pos;
            r_sat     <= n_sat;
        end
    end

    // window and latched pattern contents
    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_win       <= n_win;
            r_act_bytes <= cur_bytes;
            r_act_need  <= cur_need;
        end
    end

    `SAD_ASSERT_IMP(a_fill_within_len, i_clk, i_rst_n, 1'b1, r_fill <= r_act_len)
    `SAD_ASSERT_IMP(a_len_in_range, i_clk, i_rst_n, 1'b1, (r_act_len != '0) && (32'(r_act_len) <= sad_pkg::MAX_PATTERN))
    `SAD_ASSERT_IMP(a_sat_at_max, i_clk, i_rst_n, r_sat, r_pos == sad_pkg::POS_MAX)
    `SAD_ASSERT_NEXT(a_start_restarts, i_clk, i_rst_n, i_fire && i_item.first_of_text, (r_fill == sad_pkg::LEN_BITS'(1)) && !r_sat && r_loaded)

endmodule

// File: tb/sv/sliding_anagram_detector_unit_tb.sv
// self-checking testbench for the sliding-window anagram detector
`timescale 1ns / 1ps

module sliding_anagram_detector_unit_tb;
    import sad_pkg::*;

    localparam int RANDOM_ITEMS   = 1500;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int MAX_REPORTS    = 100;
    localparam int HOLD_CYCLES    = 150;
    // index 3 is not a register, writes to it must be ignored
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED_INDEX = 2'd3;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // block ports
    logic                     in_valid  = 1'b0;
    logic                     in_stall;
    t_in_item                 in_data   = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    t_out_item                out_data;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data  = '0;

    sliding_anagram_detector_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // traffic shaping knobs shared by the tests
    bit          send_idle_on = 1'b1;
    bit          recv_idle_on = 1'b1;
    bit          hold_request = 1'b0;
    int unsigned stall_left   = 0;
    int unsigned bytes_sent   = 0;
    int unsigned error_count  = 0;

    t_out_item expected_results [$];

    // register shadow and detector state
    logic [LEN_REG_BITS-1:0]  shadow_len  = 5'd1;
    logic [63:0]              shadow_low  = '0;
    logic [63:0]              shadow_high = '0;
    logic [7:0]               window_bytes [MAX_PATTERN] = '{default: '0};
    int                       deficit [256] = '{default: 0};
    int                       unmet   = 0;
    int                       fill    = 0;
    int                       win_len = 1;
    logic [POSITION_BITS-1:0] next_pos  = '0;
    bit                       pos_stuck = 1'b0;

    // mostly no gap, some short ones, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // zero acts as one, anything above the maximum as the maximum
    function automatic int clamp_window(input logic [LEN_REG_BITS-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_PATTERN) return MAX_PATTERN;
        return int'(v);
    endfunction

    // advance the detector state by one text byte and return its result
    function automatic t_out_item predict_result(input t_in_item item);
        t_out_item                res;
        logic [127:0]             pat;
        logic [7:0]               c;
        logic [7:0]               old;
        logic [POSITION_BITS-1:0] pos;
        bit                       ovf;
        c = item.text_byte;
        // start of text: reload deficits from the latched pattern
        if (item.first_of_text) begin
            pat     = {shadow_high, shadow_low};
            win_len = clamp_window(shadow_len);
            unmet   = 0;
            foreach (deficit[i]) deficit[i] = 0;
            for (int k = 0; k < win_len; k++) begin
                deficit[pat[8*k +: 8]]++;
                if (deficit[pat[8*k +: 8]] == 1) unmet++;
            end
            foreach (window_bytes[i]) window_bytes[i] = '0;
            fill      = 0;
            next_pos  = '0;
            pos_stuck = 1'b0;
        end
        pos = next_pos;
        ovf = pos_stuck;
        // full window: the oldest byte leaves
        if (fill >= win_len) begin
            old = window_bytes[0];
            deficit[old]++;
            if (deficit[old] == 1) unmet++;
            for (int k = 0; k + 1 < win_len; k++) window_bytes[k] = window_bytes[k + 1];
            window_bytes[win_len - 1] = c;
            fill = win_len;
        end else begin
            window_bytes[fill] = c;
            fill++;
        end
        deficit[c]--;
        if (deficit[c] == 0) unmet--;
        res       = '0;
        res.match = (fill == win_len) && (unmet == 0);
        if (res.match) res.window_start = START_BITS'(pos - POSITION_BITS'(win_len - 1));
        res.position_overflow = ovf;
        if (next_pos == POS_MAX) pos_stuck = 1'b1;
        else next_pos++;
        return res;
    endfunction

    // one text byte transfer, with an optional gap in front
    task automatic send_text_byte(input logic [7:0] b, input bit first);
        t_in_item    item;
        int unsigned gap;
        item.text_byte     = b;
        item.first_of_text = first;
        gap = send_idle_on ? pick_gap() : 0;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (in_stall);
        expected_results = {expected_results, predict_result(item)};
        bytes_sent++;
    endtask

    // register write, issued only once every pending result is back
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [63:0] value);
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_PATTERN_LENGTH: shadow_len  = value[LEN_REG_BITS-1:0];
            CFG_PATTERN_LOW:    shadow_low  = value;
            CFG_PATTERN_HIGH:   shadow_high = value;
            default: ;
        endcase
    endtask

    task automatic set_pattern(input logic [63:0] len_word,
                               input logic [MAX_PATTERN-1:0][7:0] pat_bytes);
        write_reg(CFG_PATTERN_LENGTH, len_word);
        write_reg(CFG_PATTERN_LOW, pat_bytes[7:0]);
        write_reg(CFG_PATTERN_HIGH, pat_bytes[15:8]);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    endtask

    // receiver stall: random gaps, or one long hold when a test asks for it
    always @(posedge clk) begin : receiver_stall
        int unsigned g;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_request) begin
            hold_request = 1'b0;
            stall_left   = HOLD_CYCLES - 1;
            out_stall   <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left--;
            out_stall <= 1'b1;
        end else begin
            g = recv_idle_on ? pick_gap() : 0;
            if (g != 0) begin
                stall_left = g - 1;
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // compare every result transfer with the oldest expectation
    always @(posedge clk) begin : result_check
        t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_results.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t ns: result with nothing expected, expected none, actual %0h",
                             $time, out_data);
            end else begin
                want = expected_results.pop_front();
                if (out_data.match !== want.match)
                    report_mismatch("match", want.match, out_data.match);
                if (out_data.window_start !== want.window_start)
                    report_mismatch("window_start", want.window_start, out_data.window_start);
                if (out_data.position_overflow !== want.position_overflow)
                    report_mismatch("position_overflow", want.position_overflow,
                                    out_data.position_overflow);
            end
        end
    end

    // end the run when nothing moves for too long
    int unsigned quiet_cycles = 0;
    always @(posedge clk) begin : watchdog
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t ns: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // bytes before any start of text match at their own position
    task automatic test_reset_state();
        send_text_byte(8'h00, 1'b0);
        send_text_byte(8'hFF, 1'b0);
        send_text_byte(8'h5A, 1'b0);
    endtask

    task automatic test_directed_cases();
        logic [MAX_PATTERN-1:0][7:0] pat;
        logic [63:0]                 word;
        // pattern "abc" with junk in the unused bytes
        pat    = {$urandom, $urandom, $urandom, $urandom};
        pat[0] = 8'h61;
        pat[1] = 8'h62;
        pat[2] = 8'h63;
        set_pattern(64'd3, pat);
        send_text_byte(8'h63, 1'b1);
        send_text_byte(8'h61, 1'b0);
        send_text_byte(8'h62, 1'b0);
        send_text_byte(8'h63, 1'b0);
        send_text_byte(8'h78, 1'b0);
        // new length only counts from the next start of text
        write_reg(CFG_PATTERN_LENGTH, 64'd2);
        send_text_byte(8'h61, 1'b0);
        send_text_byte(8'h62, 1'b0);
        send_text_byte(8'h62, 1'b1);
        send_text_byte(8'h61, 1'b0);
        // zero length with high junk bits acts as one, pattern byte 0xff
        word      = {$urandom, $urandom};
        word[4:0] = 5'd0;
        write_reg(CFG_PATTERN_LENGTH, word);
        word      = {$urandom, $urandom};
        word[7:0] = 8'hFF;
        write_reg(CFG_PATTERN_LOW, word);
        send_text_byte(8'hFF, 1'b1);
        send_text_byte(8'h00, 1'b0);
        send_text_byte(8'hFF, 1'b0);
        // write to a missing register leaves the pattern alone
        write_reg(CFG_UNUSED_INDEX, {$urandom, $urandom});
        send_text_byte(8'hFF, 1'b1);
        send_text_byte(8'h00, 1'b0);
    endtask

    // receiver holds off long enough for the block to stall its input
    task automatic test_back_pressure();
        send_idle_on = 1'b0;
        recv_idle_on = 1'b0;
        set_pattern(64'd4, {8{8'h31, 8'h32}});
        @(negedge clk);
        hold_request = 1'b1;
        @(posedge clk);
        for (int i = 0; i < 40; i++)
            send_text_byte(8'h31 + 8'($urandom_range(0, 1)), i == 0);
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
    endtask

    // random texts drawn from a small alphabet, with planted anagrams
    task automatic test_random_texts();
        logic [MAX_PATTERN-1:0][7:0] pat;
        logic [7:0]                  alphabet [4];
        logic [7:0]                  planted [$];
        logic [63:0]                 len_word;
        logic [7:0]                  tmp;
        int                          n_alpha;
        int                          text_len;
        int                          act;
        int                          j;
        int                          r;
        int                          text_count;
        bit                          first;
        int unsigned                 target;
        target     = bytes_sent + RANDOM_ITEMS;
        text_count = 0;
        while (bytes_sent < target) begin
            send_idle_on = ($urandom_range(0, 3) != 0);
            recv_idle_on = ($urandom_range(0, 3) != 0);
            // new pattern and length for most texts
            if (text_count == 0 || $urandom_range(0, 3) != 0) begin
                n_alpha = $urandom_range(1, 4);
                for (int k = 0; k < 4; k++) alphabet[k] = 8'($urandom_range(0, 255));
                for (int k = 0; k < MAX_PATTERN; k++)
                    pat[k] = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                        : alphabet[$urandom_range(0, n_alpha - 1)];
                len_word = {$urandom, $urandom};
                r        = $urandom_range(0, 9);
                len_word[4:0] = (r == 0) ? 5'd0 :
                                (r == 1) ? 5'd16 :
                                (r == 2) ? 5'($urandom_range(17, 31)) :
                                (r == 3) ? 5'd1 : 5'($urandom_range(2, 15));
                set_pattern(len_word, pat);
            end
            text_count++;
            act      = clamp_window(shadow_len);
            first    = ($urandom_range(0, 9) != 0);
            text_len = $urandom_range(1, 48);
            for (int i = 0; i < text_len; i++) begin
                // now and then plant a shuffled copy of the active pattern
                if (planted.size() == 0 && $urandom_range(0, 4) == 0) begin
                    for (int k = 0; k < act; k++) planted = {planted, pat[k]};
                    for (int k = act - 1; k > 0; k--) begin
                        j          = $urandom_range(0, k);
                        tmp        = planted[k];
                        planted[k] = planted[j];
                        planted[j] = tmp;
                    end
                end
                if (planted.size() != 0) tmp = planted.pop_front();
                else if ($urandom_range(0, 6) == 0) tmp = 8'($urandom_range(0, 255));
                else tmp = alphabet[$urandom_range(0, n_alpha - 1)];
                // a rare restart in the middle of a text
                send_text_byte(tmp, first || ($urandom_range(0, 63) == 0));
                first = 1'b0;
            end
            planted.delete();
        end
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
    endtask

    // test sequence
    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_directed_cases();
        test_back_pressure();
        test_random_texts();
        in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+hdl
hdl/sad_pkg.sv
hdl/sad_cfg.sv
hdl/sad_core.sv
hdl/sliding_anagram_detector_unit.sv
tb/sv/sliding_anagram_detector_unit_tb.sv
